// ===== src/rav_pkg.sv =====
// Shared types and constants for the repulsive avoidance vector block.
// No dependencies.
package rav_pkg;

    // configuration register map
    typedef enum logic [1:0] {
        t_REG_SAFE = 2'd0,
        t_REG_MIN  = 2'd1,
        t_REG_MAX  = 2'd2
    } t_reg_idx;

    localparam int CFG_W     = 16;  // configuration register width
    localparam int FRAC_W    = 16;  // fraction bits of the force term
    localparam int FORCE_W   = 32;  // Q.16 force magnitude
    localparam int OUT_W     = 17;  // signed output component
    localparam int CNT_W     = 8;   // contributor count
    localparam int OUT_DATA_W = 64; // 3*17 + 1 + 8 = 60, padded to bytes

    localparam logic [CFG_W-1:0] SAFE_RST = 16'd2560;
    localparam logic [CFG_W-1:0] MIN_RST  = 16'd26;
    localparam logic [CFG_W-1:0] MAX_RST  = 16'd1280;

endpackage

// ===== src/rav_mul.sv =====
// Bit-serial shift-and-add unsigned multiplier, one multiplier bit per cycle.
// Stops as soon as the remaining multiplier bits are zero. No dependencies.
module rav_mul #(
    parameter int WA = 32,
    parameter int WB = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_go,
    input  logic [WA-1:0]    i_a,
    input  logic [WB-1:0]    i_b,
    output logic             o_busy,
    output logic [WA+WB-1:0] o_prod
);
    logic [WA+WB-1:0] r_acc;
    logic [WA+WB-1:0] r_a;
    logic [WB-1:0]    r_b;
    logic             r_busy;

    // shift multiplicand left, multiplier right, add on set bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_go) begin
            r_acc  <= '0;
            r_a    <= (WA+WB)'(i_a);
            r_b    <= i_b;
            r_busy <= 1'b1;
        end else if (r_busy) begin
            if (r_b == '0) begin
                r_busy <= 1'b0;
            end else begin
                if (r_b[0]) begin
                    r_acc <= r_acc + r_a;
                end
                r_a <= r_a << 1;
                r_b <= r_b >> 1;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_prod = r_acc;
endmodule

// ===== src/rav_sqrt.sv =====
// Restoring integer square root, one root bit per cycle (floor result).
// No dependencies.
module rav_sqrt #(
    parameter int IW = 68
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_go,
    input  logic [IW-1:0]     i_rad,
    output logic              o_busy,
    output logic [IW/2-1:0]   o_root
);
    localparam int RW  = IW / 2;
    localparam int CTW = $clog2(RW + 1);

    logic [IW-1:0]  r_rad;
    logic [RW+1:0]  r_rem;
    logic [RW-1:0]  r_root;
    logic [CTW-1:0] r_cnt;
    logic           r_busy;
    logic [RW+1:0]  w_t;
    logic [RW+1:0]  w_trial;

    // bring down two radicand bits, try root*4+1
    assign w_t     = {r_rem[RW-1:0], r_rad[IW-1 -: 2]};
    assign w_trial = {r_root, 2'b01};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_go) begin
            r_rad  <= i_rad;
            r_rem  <= '0;
            r_root <= '0;
            r_cnt  <= CTW'(RW);
            r_busy <= 1'b1;
        end else if (r_busy) begin
            if (w_t >= w_trial) begin
                r_rem  <= w_t - w_trial;
                r_root <= {r_root[RW-2:0], 1'b1};
            end else begin
                r_rem  <= w_t;
                r_root <= {r_root[RW-2:0], 1'b0};
            end
            r_rad <= r_rad << 2;
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CTW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_root = r_root;
endmodule

// ===== src/rav_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// No dependencies.
module rav_div #(
    parameter int NW = 44,
    parameter int DVW = 34
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_go,
    input  logic [NW-1:0]  i_num,
    input  logic [DVW-1:0] i_den,
    output logic           o_busy,
    output logic [NW-1:0]  o_quot
);
    localparam int CTW = $clog2(NW + 1);

    logic [NW-1:0]  r_num;   // dividend shifts out, quotient shifts in
    logic [DVW:0]   r_rem;
    logic [DVW-1:0] r_den;
    logic [CTW-1:0] r_cnt;
    logic           r_busy;
    logic [DVW:0]   w_t;

    assign w_t = {r_rem[DVW-1:0], r_num[NW-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_go) begin
            r_num  <= i_num;
            r_den  <= i_den;
            r_rem  <= '0;
            r_cnt  <= CTW'(NW);
            r_busy <= 1'b1;
        end else if (r_busy) begin
            if (w_t >= {1'b0, r_den}) begin
                r_rem <= w_t - {1'b0, r_den};
                r_num <= {r_num[NW-2:0], 1'b1};
            end else begin
                r_rem <= w_t;
                r_num <= {r_num[NW-2:0], 1'b0};
            end
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CTW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_num;
endmodule

// ===== src/repulsive_avoidance_vector.sv =====
// Repulsive avoidance vector: per-neighbor repulsion sum with magnitude limit.
// Uses rav_pkg, rav_mul, rav_sqrt and rav_div.
//
// Usage: each slave beat carries own and neighbor positions (signed Q.8),
// tuser flags a real neighbor, tlast closes the neighbor set. A valid neighbor
// whose distance lies strictly between min_distance and safe_distance adds
// (safe-dist)/dist * d to three saturating sums. On the tlast beat the sum
// vector is scaled down to the magnitude limit if longer, and one master beat
// is issued; the sums and the contributor count then clear.
// Timing: one beat at a time, tready high only while idle. An invalid beat
// goes to the tlast check; a valid one is squared, rooted and band-checked,
// and in band adds a force division, multiply and accumulate. The tlast beat
// adds a magnitude square and root, plus a multiply and three per-axis
// divisions when limiting. Serial multipliers stop early on short operands;
// root and divider span RW = max(CW, AW) + 1 and NW = max(32, AW + 16) bits.
// A stalled master side keeps one result in the output register; the next
// tlast beat waits to emit and input stalls behind it. Reset loads register
// defaults, clears sums. Configuration must be written while idle (unenforced).
module repulsive_avoidance_vector #(
    parameter int COORD_WIDTH = 24,
    parameter int ACC_WIDTH   = 28
) (
    input  logic i_clk,
    input  logic i_rst_n,
    // fields low to high: own_x, own_y, own_z, nbr_x, nbr_y, nbr_z, zero pad
    input  logic [((6*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    input  logic s_axis_tuser,   // nbr_valid
    input  logic s_axis_tlast,   // last_item
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // fields low to high: vec_x, vec_y, vec_z, was_limited, contributors, pad
    output logic [rav_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    input  logic i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [rav_pkg::CFG_W-1:0] i_cfg_data
);
    localparam int CW   = COORD_WIDTH;
    localparam int AW   = ACC_WIDTH;
    localparam int DW   = CW + 1;
    localparam int MA0  = (CW > AW) ? CW : AW;
    localparam int MA   = (MA0 > rav_pkg::FORCE_W) ? MA0 : rav_pkg::FORCE_W;
    localparam int PW   = 2 * MA;
    localparam int SQ1  = 2 * CW + 2;
    localparam int SQ2  = 2 * AW + 2;
    localparam int SQW  = (SQ1 > SQ2) ? SQ1 : SQ2;
    localparam int RW   = SQW / 2;
    localparam int NW   = (AW + 16 > 32) ? AW + 16 : 32;
    localparam int DVW  = (RW > 16) ? RW : 16;
    localparam int TW   = rav_pkg::FORCE_W + 1;
    localparam int SW   = ((AW > TW) ? AW : TW) + 1;
    localparam int OW   = rav_pkg::OUT_W;
    localparam logic signed [SW-1:0] SAT_HI = SW'((64'sd1 <<< (AW-1)) - 64'sd1);
    localparam logic signed [SW-1:0] SAT_LO = SW'(-(64'sd1 <<< (AW-1)));

    typedef enum logic [4:0] {
        ST_IDLE, ST_ITEM, ST_SQ, ST_SUM, ST_ROOT, ST_CHK, ST_FDIV, ST_FMUL,
        ST_FACC, ST_LAST, ST_MSQ, ST_MSUM, ST_MROOT, ST_MCHK, ST_VMUL,
        ST_VGO, ST_VDIV, ST_EMIT
    } t_state;

    t_state r_state;

    logic [rav_pkg::CFG_W-1:0] r_safe, r_min, r_max;
    logic signed [DW-1:0] r_d [3];
    logic signed [AW-1:0] r_sum [3];
    logic [rav_pkg::CNT_W-1:0] r_hits;
    logic r_valid, r_last, r_lim;
    logic [RW-1:0] r_dist, r_mag;
    logic [1:0] r_lane;
    logic signed [OW-1:0] r_vout [3];
    logic [rav_pkg::OUT_DATA_W-1:0] r_odata;
    logic r_ovalid;

    logic r_mgo, r_sgo, r_dgo;
    logic [MA-1:0] r_ma [3], r_mb [3];
    logic [SQW-1:0] r_rad;
    logic [NW-1:0] r_dnum;
    logic [DVW-1:0] r_dden;

    logic [2:0] w_mbusy;
    logic [PW-1:0] w_prod [3];
    logic w_sbusy, w_dbusy;
    logic [RW-1:0] w_root;
    logic [NW-1:0] w_quot;

    // unit outputs and helper values
    logic signed [DW-1:0] w_din [3];
    logic [CW-1:0] w_dabs [3];
    logic [AW-1:0] w_sabs [3];
    logic signed [SW-1:0] w_acc [3];
    logic [SQW-1:0] w_sqsum;
    logic w_mdone;
    logic [OW-1:0] w_qmag;

    // three multiplier lanes, one per axis
    for (genvar g = 0; g < 3; g++) begin : g_lane
        rav_mul #(.WA(MA), .WB(MA)) u_mul (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_go(r_mgo),
            .i_a(r_ma[g]), .i_b(r_mb[g]),
            .o_busy(w_mbusy[g]), .o_prod(w_prod[g])
        );
    end

    rav_sqrt #(.IW(SQW)) u_sqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_go(r_sgo), .i_rad(r_rad),
        .o_busy(w_sbusy), .o_root(w_root)
    );

    rav_div #(.NW(NW), .DVW(DVW)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_go(r_dgo), .i_num(r_dnum),
        .i_den(r_dden), .o_busy(w_dbusy), .o_quot(w_quot)
    );

    // per-axis differences, magnitudes and saturating sums
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_din[i] = DW'($signed(s_axis_tdata[i*CW +: CW]))
                     - DW'($signed(s_axis_tdata[(i+3)*CW +: CW]));
            w_dabs[i] = r_d[i][DW-1] ? CW'(-r_d[i]) : CW'(r_d[i]);
            w_sabs[i] = r_sum[i][AW-1] ? AW'(-r_sum[i]) : AW'(r_sum[i]);
            w_acc[i] = SW'(r_sum[i]) + (r_d[i][DW-1]
                     ? -SW'({1'b0, w_prod[i][rav_pkg::FRAC_W +: rav_pkg::FORCE_W]})
                     :  SW'({1'b0, w_prod[i][rav_pkg::FRAC_W +: rav_pkg::FORCE_W]}));
        end
        w_sqsum = SQW'(w_prod[0]) + SQW'(w_prod[1]) + SQW'(w_prod[2]);
        w_mdone = !r_mgo && (w_mbusy == 3'b000);
        w_qmag  = OW'(w_quot);
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

    // sequencer, configuration and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_safe   <= rav_pkg::SAFE_RST;
            r_min    <= rav_pkg::MIN_RST;
            r_max    <= rav_pkg::MAX_RST;
            r_hits   <= '0;
            r_ovalid <= 1'b0;
            r_mgo    <= 1'b0;
            r_sgo    <= 1'b0;
            r_dgo    <= 1'b0;
            r_lim    <= 1'b0;
            r_lane   <= '0;
            for (int i = 0; i < 3; i++) begin
                r_sum[i] <= '0;
            end
        end else begin
            // start pulses last one cycle; no state raises one while it is high
            if (r_mgo) r_mgo <= 1'b0;
            if (r_sgo) r_sgo <= 1'b0;
            if (r_dgo) r_dgo <= 1'b0;
            if (r_ovalid && m_axis_tready && r_state != ST_EMIT) begin
                r_ovalid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    rav_pkg::t_REG_SAFE: r_safe <= i_cfg_data;
                    rav_pkg::t_REG_MIN:  r_min  <= i_cfg_data;
                    rav_pkg::t_REG_MAX:  r_max  <= i_cfg_data;
                    default: ;
                endcase
            end
            case (r_state)
                ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        for (int i = 0; i < 3; i++) begin
                            r_d[i] <= w_din[i];
                        end
                        r_valid <= s_axis_tuser;
                        r_last  <= s_axis_tlast;
                        r_state <= ST_ITEM;
                    end
                end
                ST_ITEM: begin
                    if (r_valid) begin
                        for (int i = 0; i < 3; i++) begin
                            r_ma[i] <= MA'(w_dabs[i]);
                            r_mb[i] <= MA'(w_dabs[i]);
                        end
                        r_mgo   <= 1'b1;
                        r_state <= ST_SQ;
                    end else begin
                        r_state <= ST_LAST;
                    end
                end
                ST_SQ: begin
                    if (w_mdone) r_state <= ST_SUM;
                end
                ST_SUM: begin
                    r_rad   <= w_sqsum;
                    r_sgo   <= 1'b1;
                    r_state <= ST_ROOT;
                end
                ST_ROOT: begin
                    if (!r_sgo && !w_sbusy) begin
                        r_dist  <= w_root;
                        r_state <= ST_CHK;
                    end
                end
                ST_CHK: begin
                    // inside the band: start force division
                    if (r_dist > RW'(r_min) && r_dist < RW'(r_safe)) begin
                        r_dnum  <= NW'({16'(r_safe - r_dist[15:0]),
                                        {rav_pkg::FRAC_W{1'b0}}});
                        r_dden  <= DVW'(r_dist);
                        r_dgo   <= 1'b1;
                        r_state <= ST_FDIV;
                    end else begin
                        r_state <= ST_LAST;
                    end
                end
                ST_FDIV: begin
                    if (!r_dgo && !w_dbusy) begin
                        for (int i = 0; i < 3; i++) begin
                            r_ma[i] <= MA'(w_quot[rav_pkg::FORCE_W-1:0]);
                            r_mb[i] <= MA'(w_dabs[i]);
                        end
                        r_mgo   <= 1'b1;
                        r_state <= ST_FMUL;
                    end
                end
                ST_FMUL: begin
                    if (w_mdone) r_state <= ST_FACC;
                end
                ST_FACC: begin
                    for (int i = 0; i < 3; i++) begin
                        if (w_acc[i] > SAT_HI)      r_sum[i] <= AW'(SAT_HI);
                        else if (w_acc[i] < SAT_LO) r_sum[i] <= AW'(SAT_LO);
                        else                        r_sum[i] <= AW'(w_acc[i]);
                    end
                    if (r_hits != '1) r_hits <= r_hits + 1'b1;
                    r_state <= ST_LAST;
                end
                ST_LAST: begin
                    if (r_last) begin
                        for (int i = 0; i < 3; i++) begin
                            r_ma[i] <= MA'(w_sabs[i]);
                            r_mb[i] <= MA'(w_sabs[i]);
                        end
                        r_mgo   <= 1'b1;
                        r_state <= ST_MSQ;
                    end else begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_MSQ: begin
                    if (w_mdone) r_state <= ST_MSUM;
                end
                ST_MSUM: begin
                    r_rad   <= w_sqsum;
                    r_sgo   <= 1'b1;
                    r_state <= ST_MROOT;
                end
                ST_MROOT: begin
                    if (!r_sgo && !w_sbusy) begin
                        r_mag   <= w_root;
                        r_state <= ST_MCHK;
                    end
                end
                ST_MCHK: begin
                    // longer than the limit: scale each axis by max/mag
                    if (r_mag > RW'(r_max)) begin
                        for (int i = 0; i < 3; i++) begin
                            r_ma[i] <= MA'(w_sabs[i]);
                            r_mb[i] <= MA'(r_max);
                        end
                        r_mgo   <= 1'b1;
                        r_lim   <= 1'b1;
                        r_state <= ST_VMUL;
                    end else begin
                        for (int i = 0; i < 3; i++) begin
                            r_vout[i] <= OW'(r_sum[i]);
                        end
                        r_lim   <= 1'b0;
                        r_state <= ST_EMIT;
                    end
                end
                ST_VMUL: begin
                    if (w_mdone) begin
                        r_lane  <= '0;
                        r_state <= ST_VGO;
                    end
                end
                ST_VGO: begin
                    r_dnum  <= NW'(w_prod[r_lane]);
                    r_dden  <= DVW'(r_mag);
                    r_dgo   <= 1'b1;
                    r_state <= ST_VDIV;
                end
                ST_VDIV: begin
                    if (!r_dgo && !w_dbusy) begin
                        r_vout[r_lane] <= r_sum[r_lane][AW-1] ? -w_qmag : w_qmag;
                        r_lane <= r_lane + 1'b1;
                        r_state <= (r_lane == 2'd2) ? ST_EMIT : ST_VGO;
                    end
                end
                ST_EMIT: begin
                    if (!r_ovalid || m_axis_tready) begin
                        r_odata <= rav_pkg::OUT_DATA_W'({r_hits, r_lim,
                                   r_vout[2], r_vout[1], r_vout[0]});
                        r_ovalid <= 1'b1;
                        r_hits   <= '0;
                        for (int i = 0; i < 3; i++) begin
                            r_sum[i] <= '0;
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end
endmodule
